/* design/ird_pkg.sv */
// Package for the infrared remote pulse decoder.
// Holds the receive phase type, the timing windows and the stream widths.
// No dependencies.
package ird_pkg;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhLeader = 2'd1,
    PhBits   = 2'd2
  } phase_e;

  localparam int unsigned DurW      = 16;
  localparam int unsigned FrameW    = 48;
  localparam int unsigned NecBits   = 32;
  localparam int unsigned CountW    = 6;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 56;

  // Mode values of the frame_mode register.
  localparam logic ModeNec    = 1'b0;
  localparam logic ModeAircon = 1'b1;

  localparam logic [CountW-1:0] NecLen    = 6'd32;
  localparam logic [CountW-1:0] AirconLen = 6'd48;

  // Inclusive windows in microseconds.
  localparam logic [DurW-1:0] NecLeadMarkLo  = 16'd8000;
  localparam logic [DurW-1:0] NecLeadMarkHi  = 16'd10000;
  localparam logic [DurW-1:0] LeadLo         = 16'd3500;
  localparam logic [DurW-1:0] LeadHi         = 16'd5500;
  localparam logic [DurW-1:0] NecBitMarkLo   = 16'd400;
  localparam logic [DurW-1:0] AirBitMarkLo   = 16'd350;
  localparam logic [DurW-1:0] ShortHi        = 16'd700;
  localparam logic [DurW-1:0] ZeroLo         = 16'd400;
  localparam logic [DurW-1:0] NecOneLo       = 16'd1550;
  localparam logic [DurW-1:0] AirOneLo       = 16'd1500;
  localparam logic [DurW-1:0] OneHi          = 16'd1800;

  function automatic logic in_win(logic [DurW-1:0] v, logic [DurW-1:0] lo,
                                  logic [DurW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

/* design/ir_remote_pulse_decoder.sv */
// Top level of the infrared remote pulse decoder (NEC and 48-bit aircon).
// Depends on ird_pkg for the phase type, windows and widths.
// A result is registered and valid in the cycle after its pulse transaction is accepted.
// Throughput: one pulse per cycle while the sink takes each result; the single result register sets the rate.
// A new pulse is taken while the result is being taken by the sink.
// Reset (rst_ni low, asynchronous): phase idle, bit count and shift register
// cleared, frame_mode set to NEC, no result pending.
module ir_remote_pulse_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,   // frame_mode
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ird_pkg::InTdataW-1:0]   s_tdata,       // [15:0] duration_us
  input  logic                           s_tuser,       // [0] interval_was_low
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ird_pkg::OutTdataW-1:0]  m_tdata,       // [47:0] frame_bits,
                                                        // [49:48] rx_phase, rest 0
  output logic                           m_tlast,       // frame_done
  output logic                           m_tuser        // [0] decode_error
);

  logic                          mode_q;
  ird_pkg::phase_e               phase_q, phase_d;
  logic [ird_pkg::CountW-1:0]    count_q, count_d;
  logic [ird_pkg::FrameW-1:0]    shift_q, shift_d;

  logic                          out_valid_q;
  logic                          done_q, done_d;
  logic                          err_q, err_d;
  logic [ird_pkg::FrameW-1:0]    frame_q, frame_d;
  ird_pkg::phase_e               out_phase_q;

  logic                          accept;
  logic                          is_low;
  logic [ird_pkg::DurW-1:0]      dur;
  logic                          aircon;
  logic                          lead_mark_ok, bit_mark_ok, lead_space_ok;
  logic                          bit_zero, bit_one;
  logic [ird_pkg::FrameW-1:0]    shifted;
  logic [ird_pkg::CountW-1:0]    count_inc;
  logic [ird_pkg::CountW-1:0]    target;

  assign s_tready = !out_valid_q || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_low   = s_tuser;
  assign dur      = s_tdata;
  assign aircon   = (mode_q == ird_pkg::ModeAircon);

  assign lead_mark_ok  = aircon
      ? ird_pkg::in_win(dur, ird_pkg::LeadLo, ird_pkg::LeadHi)
      : ird_pkg::in_win(dur, ird_pkg::NecLeadMarkLo, ird_pkg::NecLeadMarkHi);
  assign bit_mark_ok   = aircon
      ? ird_pkg::in_win(dur, ird_pkg::AirBitMarkLo, ird_pkg::ShortHi)
      : ird_pkg::in_win(dur, ird_pkg::NecBitMarkLo, ird_pkg::ShortHi);
  assign lead_space_ok = ird_pkg::in_win(dur, ird_pkg::LeadLo, ird_pkg::LeadHi);
  assign bit_zero      = ird_pkg::in_win(dur, ird_pkg::ZeroLo, ird_pkg::ShortHi);
  assign bit_one       = aircon
      ? ird_pkg::in_win(dur, ird_pkg::AirOneLo, ird_pkg::OneHi)
      : ird_pkg::in_win(dur, ird_pkg::NecOneLo, ird_pkg::OneHi);

  // Aircon shifts MSB first over 48 bits; NEC shifts LSB first into bit 31.
  assign shifted = aircon
      ? {shift_q[ird_pkg::FrameW-2:0], bit_one}
      : {{(ird_pkg::FrameW-ird_pkg::NecBits){1'b0}}, bit_one,
         shift_q[ird_pkg::NecBits-1:1]};
  assign count_inc = count_q + 1'b1;
  assign target    = aircon ? ird_pkg::AirconLen : ird_pkg::NecLen;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      ird_pkg::PhIdle: begin
        if (is_low && lead_mark_ok) phase_d = ird_pkg::PhLeader;
      end
      ird_pkg::PhLeader: begin
        if (!is_low) phase_d = lead_space_ok ? ird_pkg::PhBits : ird_pkg::PhIdle;
      end
      ird_pkg::PhBits: begin
        if (is_low) begin
          if (!bit_mark_ok) phase_d = ird_pkg::PhIdle;
        end else if (!bit_zero && !bit_one) begin
          phase_d = ird_pkg::PhIdle;
        end else if (count_inc >= target) begin
          phase_d = ird_pkg::PhIdle;
        end
      end
      default: phase_d = ird_pkg::PhIdle;
    endcase
  end

  // Datapath and result values.
  always_comb begin
    count_d = count_q;
    shift_d = shift_q;
    done_d  = 1'b0;
    err_d   = 1'b0;
    frame_d = '0;
    unique case (phase_q)
      ird_pkg::PhIdle: begin
        if (is_low && lead_mark_ok) begin
          count_d = '0;
          shift_d = '0;
        end
      end
      ird_pkg::PhLeader: begin
        if (!is_low && !lead_space_ok) begin
          err_d   = 1'b1;
          count_d = '0;
          shift_d = '0;
        end
      end
      ird_pkg::PhBits: begin
        if (is_low) begin
          if (!bit_mark_ok) begin
            err_d   = 1'b1;
            count_d = '0;
            shift_d = '0;
          end
        end else if (!bit_zero && !bit_one) begin
          err_d   = 1'b1;
          count_d = '0;
          shift_d = '0;
        end else if (count_inc >= target) begin
          done_d  = 1'b1;
          frame_d = shifted;
          count_d = '0;
          shift_d = '0;
        end else begin
          count_d = count_inc;
          shift_d = shifted;
        end
      end
      default: begin
        count_d = '0;
        shift_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ird_pkg::ModeNec;
      phase_q <= ird_pkg::PhIdle;
      count_q <= '0;
      shift_q <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
        shift_q <= shift_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q      <= done_d;
      err_q       <= err_d;
      frame_q     <= frame_d;
      out_phase_q <= phase_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tlast  = done_q;
  assign m_tuser  = err_q;
  assign m_tdata  = {{(ird_pkg::OutTdataW-ird_pkg::FrameW-2){1'b0}},
                     out_phase_q, frame_q};

endmodule

/* design/ird_checker.sv */
// Port-level checker for the infrared remote pulse decoder, bound to the top.
// Depends on ir_remote_pulse_decoder's port list and on ird_pkg for the phase codes.
module ird_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // A stalled result transaction keeps its data and its last flag.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // A completed frame always leaves the decoder idle and reports no error.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tlast |-> m_tdata[49:48] == ird_pkg::PhIdle && !m_tuser)
    else $error("frame done without return to idle or with error");

  // An abort clears everything and reports no frame.
  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser |-> m_tdata[49:48] == ird_pkg::PhIdle && m_tdata[47:0] == 48'd0)
    else $error("abort left phase or frame data");

  // Frame bits show only with a completed frame; the unused upper bits stay zero.
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tlast |-> m_tdata[47:0] == 48'd0 && m_tdata[55:50] == 6'd0)
    else $error("frame bits without frame done");

endmodule

bind ir_remote_pulse_decoder ird_checker u_ird_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
